@@ src/jhms_pkg.sv @@
package jhms_pkg;

    localparam int MAX_JETS   = 64;
    localparam int TOP_JETS   = 4;
    localparam int ANGLE_BITS = 12;

    localparam int QUARTER   = 1 << (ANGLE_BITS - 2);
    localparam int ROM_DEPTH = QUARTER + 1;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int SEEN_W    = $clog2(MAX_JETS + 1);

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    localparam logic [21:0]        HT_MAX    = 22'h3FFFFF;
    localparam logic signed [24:0] ACC_MAX   = 25'sd8388607;
    localparam logic signed [24:0] ACC_MIN   = -25'sd8388608;
    localparam logic [15:0]        RATIO_MAX = 16'hFFFF;
    localparam logic [6:0]         COUNT_MAX = 7'h7F;

    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = SQRT_IN_W / 2;
    localparam int DIV_N_W    = 32;
    localparam int DIV_D_W    = 16;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_PT_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_ETA_LIMIT      = 2'd1;
    localparam logic [1:0] REG_DPHI_JET_COUNT = 2'd2;

    localparam logic [15:0] PT_THRESHOLD_RST   = 16'd120;
    localparam logic [8:0]  ETA_LIMIT_RST      = 9'd250;
    localparam logic [2:0]  DPHI_JET_COUNT_RST = 3'd4;

    typedef logic [15:0] sine_rom_t [ROM_DEPTH];

    typedef struct packed {
        logic                  insert;
        logic                  clear;
        logic [15:0]           mom;
        logic [ANGLE_BITS-1:0] ang;
    } lead_ctrl_t;

    typedef struct packed {
        logic                  keep;
        logic                  valid;
        logic [15:0]           mom;
        logic [ANGLE_BITS-1:0] ang;
    } lead_link_t;

    typedef struct packed {
        logic                  found;
        logic [ANGLE_BITS-1:0] span;
    } dphi_link_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Quarter-wave sine in Q15, Taylor series to x^11 in Q30
    function automatic logic [15:0] quarter_sine(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          s;
        longint          res;
        if (r == 64'd0) return 16'd0;
        if (r >= 64'(QUARTER)) return 16'h8000;
        x  = (r * PI_HALF_Q30) >> (ANGLE_BITS - 2);
        x2 = (x * x) >> 30;
        s  = longint'(x);
        t  = ((x * x2) >> 30) / 6;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 20;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 42;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 72;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 110;
        s  = s - longint'(t);
        if (s < 0) s = 0;
        res = (s + 16384) >>> 15;
        if (res > 32768) res = 32768;
        return 16'(res);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t tab;
        for (int r = 0; r < ROM_DEPTH; r++) begin
            tab[r] = quarter_sine(64'(r));
        end
        return tab;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ src/jhms_lead_cell.sv @@
module jhms_lead_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  jhms_pkg::lead_ctrl_t                ctrl,
    input  jhms_pkg::lead_link_t                prev,
    output jhms_pkg::lead_link_t                own,
    input  logic                                use_en,
    input  logic [jhms_pkg::ANGLE_BITS-1:0]     met_ang,
    input  jhms_pkg::dphi_link_t                dphi_in,
    output jhms_pkg::dphi_link_t                dphi_out
);
    import jhms_pkg::*;

    logic                        valid_reg;
    logic [15:0]                 mom_reg;
    logic [ANGLE_BITS-1:0]       ang_reg;
    logic signed [ANGLE_BITS:0]  diff;
    logic [ANGLE_BITS:0]         adiff;
    logic [ANGLE_BITS-1:0]       span;
    logic                        used;

    always_comb begin
        own.keep  = valid_reg && (mom_reg >= ctrl.mom);
        own.valid = valid_reg;
        own.mom   = mom_reg;
        own.ang   = ang_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.insert && !own.keep) begin
            valid_reg <= prev.keep ? 1'b1 : prev.valid;
        end
    end

    // Take the new jet at the insertion point, else shift down from the neighbour
    always_ff @(posedge aclk) begin
        if (ctrl.insert && !own.keep) begin
            mom_reg <= prev.keep ? ctrl.mom : prev.mom;
            ang_reg <= prev.keep ? ctrl.ang : prev.ang;
        end
    end

    // Wrapped azimuth distance, folded into 0..half circle
    always_comb begin
        diff  = $signed({met_ang[ANGLE_BITS-1], met_ang})
              - $signed({ang_reg[ANGLE_BITS-1], ang_reg});
        adiff = diff[ANGLE_BITS] ? (ANGLE_BITS+1)'(-diff) : (ANGLE_BITS+1)'(diff);
        if (adiff > (ANGLE_BITS+1)'(1 << (ANGLE_BITS - 1))) begin
            span = ANGLE_BITS'((ANGLE_BITS+1)'(1 << ANGLE_BITS) - adiff);
        end else begin
            span = adiff[ANGLE_BITS-1:0];
        end
        used = valid_reg && use_en;
        dphi_out.found = dphi_in.found || used;
        dphi_out.span  = (used && (!dphi_in.found || span < dphi_in.span)) ? span
                       : dphi_in.span;
    end

endmodule

@@ src/jhms_sqrt.sv @@
module jhms_sqrt (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [jhms_pkg::SQRT_IN_W-1:0]      radicand,
    output logic [jhms_pkg::SQRT_OUT_W-1:0]     root,
    output jhms_pkg::unit_stat_t                stat
);
    import jhms_pkg::*;

    localparam int CNT_W = $clog2(SQRT_OUT_W);
    localparam int REM_W = SQRT_OUT_W + 2;

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [REM_W-1:0]       rem_next;
    logic [SQRT_OUT_W-1:0]  root_reg;
    logic [SQRT_OUT_W-1:0]  root_next;
    logic [SQRT_IN_W-1:0]   n_reg;
    logic [REM_W+1:0]       rem_t;
    logic [REM_W+1:0]       trial;

    // One result bit a step: bring down two radicand bits, try root*4+1
    always_comb begin
        rem_t = {rem_reg, n_reg[SQRT_IN_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        if (rem_t >= trial) begin
            rem_next  = REM_W'(rem_t - trial);
            root_next = {root_reg[SQRT_OUT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_t[REM_W-1:0];
            root_next = {root_reg[SQRT_OUT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_OUT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            root_reg <= '0;
            n_reg    <= radicand;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            n_reg    <= {n_reg[SQRT_IN_W-3:0], 2'b00};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ src/jhms_div.sv @@
module jhms_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [jhms_pkg::DIV_N_W-1:0]     dividend,
    input  logic [jhms_pkg::DIV_D_W-1:0]     divisor,
    output logic [jhms_pkg::DIV_N_W-1:0]     quotient,
    output jhms_pkg::unit_stat_t             stat
);
    import jhms_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIV_D_W-1:0]  rem_reg;
    logic [DIV_D_W-1:0]  rem_next;
    logic [DIV_D_W-1:0]  dvs_reg;
    logic [DIV_N_W-1:0]  q_reg;
    logic [DIV_D_W:0]    rem_t;
    logic                q_bit;

    // Restoring step: the dividend shifts out as the quotient shifts in
    always_comb begin
        rem_t = {rem_reg, q_reg[DIV_N_W-1]};
        q_bit = (rem_t >= {1'b0, dvs_reg});
        rem_next = q_bit ? DIV_D_W'(rem_t - {1'b0, dvs_reg}) : rem_t[DIV_D_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            q_reg   <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[DIV_N_W-2:0], q_bit};
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ src/jet_ht_mht_summary_top.sv @@
// Channel   Direction  Handshake             Word
// s_        in         s_valid / s_ready     one jet, or an empty closer, with MET
// m_        out        m_valid / m_ready     one event summary
// cfg_      in         cfg_valid / cfg_ready register index and write data
//
// An empty item or a jet that fails the cuts is done when accepted; a good jet is worked in steps:
// accept, then cosine and sine lookups in the quarter-wave ROM and two momentum multiplies.
// The last item adds a pass for the MET vector and the end of event (without the divide when
// MET is zero): two square roots, a divide, squares, sums and hand-over.
// Reset is synchronous, active low: configuration to defaults, all event state cleared.
// s_ready is low while an item is at work; a summary waiting on m_ready holds in the output
// register and the next event may start.
module jet_ht_mht_summary_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_jet_valid,
    input  logic [15:0]                           s_jet_momentum,
    input  logic signed [9:0]                     s_jet_eta,
    input  logic signed [jhms_pkg::ANGLE_BITS-1:0] s_jet_angle,
    input  logic [15:0]                           s_met_magnitude,
    input  logic signed [jhms_pkg::ANGLE_BITS-1:0] s_met_angle,
    input  logic                                  s_last_jet,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [6:0]                            m_good_jet_count,
    output logic [21:0]                           m_scalar_sum,
    output logic [21:0]                           m_vector_sum_magnitude,
    output logic [15:0]                           m_met_mht_ratio,
    output logic [15:0]                           m_lead_momentum,
    output logic [15:0]                           m_second_momentum,
    output logic signed [12:0]                    m_min_delta_angle,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [15:0]                           cfg_data
);
    import jhms_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_TA     = 5'd1;
    localparam logic [4:0] ST_TB     = 5'd2;
    localparam logic [4:0] ST_TC     = 5'd3;
    localparam logic [4:0] ST_TD     = 5'd4;
    localparam logic [4:0] ST_SQX    = 5'd5;
    localparam logic [4:0] ST_SQY    = 5'd6;
    localparam logic [4:0] ST_SUM1   = 5'd7;
    localparam logic [4:0] ST_R1GO   = 5'd8;
    localparam logic [4:0] ST_R1WAIT = 5'd9;
    localparam logic [4:0] ST_SQDX   = 5'd10;
    localparam logic [4:0] ST_SQDY   = 5'd11;
    localparam logic [4:0] ST_SUM2   = 5'd12;
    localparam logic [4:0] ST_R2GO   = 5'd13;
    localparam logic [4:0] ST_R2WAIT = 5'd14;
    localparam logic [4:0] ST_DGO    = 5'd15;
    localparam logic [4:0] ST_DWAIT  = 5'd16;
    localparam logic [4:0] ST_DONE   = 5'd17;

    logic [4:0]               state_reg;
    logic [4:0]               state_next;

    logic [15:0]              pt_thr_reg;
    logic [8:0]               eta_lim_reg;
    logic [2:0]               dphi_cnt_reg;

    logic [21:0]              ht_reg;
    logic signed [23:0]       accx_reg;
    logic signed [23:0]       accy_reg;
    logic [6:0]               count_reg;
    logic [SEEN_W-1:0]        seen_reg;
    logic                     phase_reg;

    logic [15:0]              pt_reg;
    logic [ANGLE_BITS-1:0]    ang_reg;
    logic [15:0]              met_reg;
    logic [ANGLE_BITS-1:0]    met_ang_reg;
    logic                     last_reg;

    logic [15:0]              rom_q_reg;
    logic                     rom_neg_reg;
    logic [31:0]              prod_reg;
    logic                     prod_neg_reg;
    logic signed [17:0]       mx_reg;
    logic signed [17:0]       my_reg;
    logic [49:0]              sq_reg;
    logic [50:0]              sum_reg;
    logic [21:0]              mht_reg;
    logic [15:0]              ratio_reg;

    logic                     m_valid_reg;
    logic [6:0]               o_count_reg;
    logic [21:0]              o_ht_reg;
    logic [21:0]              o_mht_reg;
    logic [15:0]              o_ratio_reg;
    logic [15:0]              o_lead_reg;
    logic [15:0]              o_second_reg;
    logic [12:0]              o_dphi_reg;

    logic                     accept;
    logic                     jet_take;
    logic                     jet_good;
    logic                     load_out;
    logic [9:0]               aeta;
    logic [21:0]              ht_next;
    logic [22:0]              ht_sum;

    logic [ANGLE_BITS-1:0]    ang_src;
    logic [ANGLE_BITS-1:0]    rom_ang;
    logic [ROM_AW-1:0]        rom_addr;
    logic [15:0]              mul_p;
    logic [32:0]              round_sum;
    logic [16:0]              mag;
    logic signed [17:0]       svec;

    logic signed [24:0]       dx;
    logic signed [24:0]       dy;
    logic signed [24:0]       sq_op;
    logic signed [49:0]       sq_full;

    logic                     sqrt_start;
    logic [SQRT_IN_W-1:0]     sqrt_in;
    logic [SQRT_OUT_W-1:0]    sqrt_root;
    unit_stat_t               sqrt_stat;
    logic                     div_start;
    logic [DIV_N_W-1:0]       div_q;
    unit_stat_t               div_stat;

    lead_ctrl_t               lead_ctrl;
    lead_link_t               link [TOP_JETS+1];
    dphi_link_t               dl   [TOP_JETS+1];

    function automatic logic signed [23:0] acc_apply(input logic signed [23:0] a,
                                                     input logic [16:0] m,
                                                     input logic neg);
        logic signed [24:0] t;
        t = neg ? (25'(a) + $signed({8'd0, m})) : (25'(a) - $signed({8'd0, m}));
        if (t > ACC_MAX) t = ACC_MAX;
        if (t < ACC_MIN) t = ACC_MIN;
        return t[23:0];
    endfunction

    // ---------------------------------------------------------------- handshakes
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign load_out  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Cuts: momentum strictly above, absolute eta strictly below
    always_comb begin
        aeta     = s_jet_eta[9] ? 10'(-s_jet_eta) : 10'(s_jet_eta);
        jet_take = accept && s_jet_valid && (seen_reg < SEEN_W'(MAX_JETS));
        jet_good = jet_take && (s_jet_momentum > pt_thr_reg)
                && (aeta < {1'b0, eta_lim_reg});
        ht_sum   = {1'b0, ht_reg} + 23'(s_jet_momentum);
        ht_next  = (ht_sum > {1'b0, HT_MAX}) ? HT_MAX : ht_sum[21:0];
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (jet_good || s_last_jet)) state_next = ST_TA;
            end
            ST_TA:     state_next = ST_TB;
            ST_TB:     state_next = ST_TC;
            ST_TC:     state_next = ST_TD;
            ST_TD: begin
                if (!phase_reg && last_reg) state_next = ST_TA;
                else if (phase_reg)         state_next = ST_SQX;
                else                        state_next = ST_IDLE;
            end
            ST_SQX:    state_next = ST_SQY;
            ST_SQY:    state_next = ST_SUM1;
            ST_SUM1:   state_next = ST_R1GO;
            ST_R1GO:   state_next = ST_R1WAIT;
            ST_R1WAIT: begin
                if (sqrt_stat.done) state_next = ST_SQDX;
            end
            ST_SQDX:   state_next = ST_SQDY;
            ST_SQDY:   state_next = ST_SUM2;
            ST_SUM2:   state_next = ST_R2GO;
            ST_R2GO:   state_next = ST_R2WAIT;
            ST_R2WAIT: begin
                if (sqrt_stat.done) state_next = (met_reg == 16'd0) ? ST_DONE : ST_DGO;
            end
            ST_DGO:    state_next = ST_DWAIT;
            ST_DWAIT: begin
                if (div_stat.done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control and event state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pt_thr_reg   <= PT_THRESHOLD_RST;
            eta_lim_reg  <= ETA_LIMIT_RST;
            dphi_cnt_reg <= DPHI_JET_COUNT_RST;
            ht_reg       <= '0;
            accx_reg     <= '0;
            accy_reg     <= '0;
            count_reg    <= '0;
            seen_reg     <= '0;
            phase_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_PT_THRESHOLD:   pt_thr_reg   <= cfg_data;
                    REG_ETA_LIMIT:      eta_lim_reg  <= cfg_data[8:0];
                    REG_DPHI_JET_COUNT: dphi_cnt_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
            // Phase low works the jet, high works the MET vector
            if (accept) begin
                phase_reg <= !jet_good;
            end else if (state_reg == ST_TD && !phase_reg && last_reg) begin
                phase_reg <= 1'b1;
            end
            if (load_out) begin
                ht_reg    <= '0;
                accx_reg  <= '0;
                accy_reg  <= '0;
                count_reg <= '0;
                seen_reg  <= '0;
            end else begin
                if (jet_take) seen_reg <= seen_reg + 1'b1;
                if (jet_good) begin
                    ht_reg <= ht_next;
                    if (count_reg != COUNT_MAX) count_reg <= count_reg + 1'b1;
                end
                if (state_reg == ST_TC && !phase_reg) begin
                    accx_reg <= acc_apply(accx_reg, mag, prod_neg_reg);
                end
                if (state_reg == ST_TD && !phase_reg) begin
                    accy_reg <= acc_apply(accy_reg, mag, prod_neg_reg);
                end
            end
            if (load_out)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- trig path
    // Cosine first (angle plus a quarter turn), then sine; fold into a quarter wave
    always_comb begin
        ang_src  = phase_reg ? met_ang_reg : ang_reg;
        rom_ang  = (state_reg == ST_TA) ? ANGLE_BITS'(ang_src + ANGLE_BITS'(QUARTER))
                 : ang_src;
        rom_addr = rom_ang[ANGLE_BITS-2] ?
                   ROM_AW'(ROM_AW'(QUARTER) - ROM_AW'(rom_ang[ANGLE_BITS-3:0]))
                 : ROM_AW'(rom_ang[ANGLE_BITS-3:0]);
        mul_p     = phase_reg ? met_reg : pt_reg;
        round_sum = {1'b0, prod_reg} + 33'd16384;
        mag       = round_sum[31:15];
        svec      = prod_neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pt_reg      <= s_jet_momentum;
            ang_reg     <= s_jet_angle;
            met_reg     <= s_met_magnitude;
            met_ang_reg <= s_met_angle;
            last_reg    <= s_last_jet;
        end
        rom_q_reg   <= SINE_ROM[rom_addr];
        rom_neg_reg <= rom_ang[ANGLE_BITS-1];
        if (state_reg == ST_TB || state_reg == ST_TC) begin
            prod_reg     <= mul_p * rom_q_reg;
            prod_neg_reg <= rom_neg_reg;
        end
        if (state_reg == ST_TC && phase_reg) mx_reg <= svec;
        if (state_reg == ST_TD && phase_reg) my_reg <= svec;
    end

    // ---------------------------------------------------------------- magnitudes
    always_comb begin
        dx = 25'(mx_reg) - 25'(accx_reg);
        dy = 25'(my_reg) - 25'(accy_reg);
        unique case (state_reg)
            ST_SQX:  sq_op = 25'(accx_reg);
            ST_SQY:  sq_op = 25'(accy_reg);
            ST_SQDX: sq_op = dx;
            ST_SQDY: sq_op = dy;
            default: sq_op = '0;
        endcase
        sq_full    = sq_op * sq_op;
        sqrt_start = (state_reg == ST_R1GO) || (state_reg == ST_R2GO);
        // Second root works on |d|^2 scaled by 2^16, giving 256*|d|, kept to 64 bits
        sqrt_in    = (state_reg == ST_R2GO) ? {sum_reg[47:0], 16'd0} : 64'(sum_reg);
        div_start  = (state_reg == ST_DGO);
    end

    always_ff @(posedge aclk) begin
        sq_reg <= $unsigned(sq_full);
        if (state_reg == ST_SQY || state_reg == ST_SQDY) sum_reg <= 51'(sq_reg);
        if (state_reg == ST_SUM1 || state_reg == ST_SUM2) sum_reg <= sum_reg + 51'(sq_reg);
        if (state_reg == ST_R1WAIT && sqrt_stat.done) begin
            mht_reg <= (sqrt_root > 32'(HT_MAX)) ? HT_MAX : sqrt_root[21:0];
        end
        if (state_reg == ST_R2WAIT && sqrt_stat.done && met_reg == 16'd0) begin
            ratio_reg <= RATIO_MAX;
        end
        if (state_reg == ST_DWAIT && div_stat.done) begin
            ratio_reg <= (div_q > 32'(RATIO_MAX)) ? RATIO_MAX : div_q[15:0];
        end
    end

    jhms_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    jhms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sqrt_root),
        .divisor  (met_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // ---------------------------------------------------------------- leader row
    always_comb begin
        lead_ctrl.insert = jet_good;
        lead_ctrl.clear  = load_out;
        lead_ctrl.mom    = s_jet_momentum;
        lead_ctrl.ang    = s_jet_angle;
        link[0].keep     = 1'b1;
        link[0].valid    = 1'b0;
        link[0].mom      = '0;
        link[0].ang      = '0;
        dl[0].found      = 1'b0;
        dl[0].span       = '0;
    end

    for (genvar i = 0; i < TOP_JETS; i++) begin : g_cell
        jhms_lead_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lead_ctrl),
            .prev     (link[i]),
            .own      (link[i+1]),
            .use_en   (4'(i) < {1'b0, dphi_cnt_reg}),
            .met_ang  (met_ang_reg),
            .dphi_in  (dl[i]),
            .dphi_out (dl[i+1])
        );
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            o_count_reg  <= count_reg;
            o_ht_reg     <= ht_reg;
            o_mht_reg    <= mht_reg;
            o_ratio_reg  <= ratio_reg;
            o_lead_reg   <= link[1].valid ? link[1].mom : 16'd0;
            o_second_reg <= link[2].valid ? link[2].mom : 16'd0;
            o_dphi_reg   <= dl[TOP_JETS].found ? 13'(dl[TOP_JETS].span) : 13'h1FFF;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_good_jet_count       = o_count_reg;
    assign m_scalar_sum           = o_ht_reg;
    assign m_vector_sum_magnitude = o_mht_reg;
    assign m_met_mht_ratio        = o_ratio_reg;
    assign m_lead_momentum        = o_lead_reg;
    assign m_second_momentum      = o_second_reg;
    assign m_min_delta_angle      = $signed(o_dphi_reg);

    // ---------------------------------------------------------------- checks
    a_cleared_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (count_reg == 7'd0 && ht_reg == 22'd0 && seen_reg == '0))
        else $error("event state not cleared after summary");

    a_leaders_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        link[2].valid |-> (link[1].valid && link[1].mom >= link[2].mom))
        else $error("leader row out of order");

    a_sqrt_free: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_start |-> !sqrt_stat.busy)
        else $error("square root restarted while busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        9'(count_reg) <= 9'(seen_reg))
        else $error("good count exceeds jets seen");

endmodule

@@ tb/jhms_summary_checker.sv @@
module jhms_summary_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic                                    s_jet_valid,
    input  logic [15:0]                             s_jet_momentum,
    input  logic signed [9:0]                       s_jet_eta,
    input  logic signed [jhms_pkg::ANGLE_BITS-1:0]  s_jet_angle,
    input  logic [15:0]                             s_met_magnitude,
    input  logic signed [jhms_pkg::ANGLE_BITS-1:0]  s_met_angle,
    input  logic                                    s_last_jet,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic [6:0]                              m_good_jet_count,
    input  logic [21:0]                             m_scalar_sum,
    input  logic [21:0]                             m_vector_sum_magnitude,
    input  logic [15:0]                             m_met_mht_ratio,
    input  logic [15:0]                             m_lead_momentum,
    input  logic [15:0]                             m_second_momentum,
    input  logic signed [12:0]                      m_min_delta_angle,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [1:0]                              cfg_index,
    input  logic [15:0]                             cfg_data,
    output int                                      fail_count,
    output int                                      pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import jhms_pkg::*;

    typedef struct packed {
        logic [6:0]         count;
        logic [21:0]        ht;
        logic [21:0]        mht;
        logic [15:0]        ratio;
        logic [15:0]        lead;
        logic [15:0]        second;
        logic signed [12:0] dphi;
    } summary_t;

    summary_t summaries[$];

    logic [15:0] thr_q;
    logic [8:0]  eta_q;
    logic [2:0]  dcnt_q;

    longint unsigned ht_sum;
    longint          vx_sum, vy_sum;
    int              n_good, n_lead, n_seen;
    logic [15:0]     lead_mom[TOP_JETS];
    longint          lead_ang[TOP_JETS];

    function automatic longint qsin(longint unsigned r);
        longint unsigned x, x2, t;
        longint s, res;
        if (r == 0) return 0;
        if (r >= QUARTER) return 32768;
        x  = (r * 64'd1686629713) >> (ANGLE_BITS - 2);
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(x);
        for (int k = 1; k <= 5; k++) begin
            t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) s -= longint'(t);
            else            s += longint'(t);
        end
        if (s < 0) s = 0;
        res = (s + 16384) / 32768;
        if (res > 32768) res = 32768;
        return res;
    endfunction

    function automatic longint sin_q15(longint a);
        longint unsigned u, quad, r;
        longint s;
        u    = longint'(a) & ((64'd1 << ANGLE_BITS) - 1);
        quad = u >> (ANGLE_BITS - 2);
        r    = u & (QUARTER - 1);
        s    = quad[0] ? qsin(QUARTER - r) : qsin(r);
        return quad[1] ? -s : s;
    endfunction

    function automatic longint scaled(longint unsigned p, longint s);
        longint unsigned mag;
        mag = (p * longint'(s < 0 ? -s : s) + 16384) >> 15;
        return s < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint clamp_acc(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   -= res + b;
                res  = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    task automatic clear_event();
        ht_sum = 0; vx_sum = 0; vy_sum = 0;
        n_good = 0; n_lead = 0; n_seen = 0;
        for (int i = 0; i < TOP_JETS; i++) begin
            lead_mom[i] = 0;
            lead_ang[i] = 0;
        end
    endtask

    task automatic add_jet(logic [15:0] pt, logic signed [9:0] eta,
                           logic signed [ANGLE_BITS-1:0] ang);
        int aeta, pos, last;
        aeta = (eta < 0) ? -int'(eta) : int'(eta);
        if (n_seen >= MAX_JETS) return;
        n_seen++;
        if (!(pt > thr_q && aeta < eta_q)) return;
        n_good++;
        ht_sum = (ht_sum + pt > 4194303) ? 4194303 : ht_sum + pt;
        vx_sum = clamp_acc(vx_sum - scaled(pt, sin_q15(longint'(ang) + QUARTER)));
        vy_sum = clamp_acc(vy_sum - scaled(pt, sin_q15(longint'(ang))));
        pos = 0;
        while (pos < n_lead && lead_mom[pos] >= pt) pos++;
        if (pos >= TOP_JETS) return;
        last = (n_lead < TOP_JETS) ? n_lead : TOP_JETS - 1;
        for (int i = last; i > pos; i--) begin
            lead_mom[i] = lead_mom[i-1];
            lead_ang[i] = lead_ang[i-1];
        end
        lead_mom[pos] = pt;
        lead_ang[pos] = ang;
        if (n_lead < TOP_JETS) n_lead++;
    endtask

    task automatic close_event(logic [15:0] met, logic signed [ANGLE_BITS-1:0] mang);
        summary_t e;
        longint mx, my, dx, dy, d, best;
        longint unsigned mht, root, ratio;
        int used;
        bit found;
        mx  = scaled(met, sin_q15(longint'(mang) + QUARTER));
        my  = scaled(met, sin_q15(longint'(mang)));
        mht = root64(longint'(vx_sum * vx_sum) + longint'(vy_sum * vy_sum));
        if (mht > 4194303) mht = 4194303;
        dx = mx - vx_sum;
        dy = my - vy_sum;
        if (met == 0) begin
            ratio = 65535;
        end else begin
            root  = root64((longint'(dx * dx) + longint'(dy * dy)) << 16);
            ratio = root / met;
            if (ratio > 65535) ratio = 65535;
        end
        used  = (dcnt_q < n_lead) ? dcnt_q : n_lead;
        found = 0;
        best  = 0;
        for (int i = 0; i < used && i < TOP_JETS; i++) begin
            d = longint'(mang) - lead_ang[i];
            if (d < 0) d = -d;
            if (d > (1 << (ANGLE_BITS - 1))) d = (1 << ANGLE_BITS) - d;
            if (!found || d < best) best = d;
            found = 1;
        end
        if (!found) best = -1;
        e.count  = (n_good > 127) ? 7'd127 : 7'(n_good);
        e.ht     = 22'(ht_sum);
        e.mht    = 22'(mht);
        e.ratio  = 16'(ratio);
        e.lead   = (n_lead > 0) ? lead_mom[0] : 16'd0;
        e.second = (n_lead > 1) ? lead_mom[1] : 16'd0;
        e.dphi   = 13'(best);
        summaries = {summaries, e};
        clear_event();
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending = summaries.size();

    initial begin
        fail_count = 0;
        thr_q = PT_THRESHOLD_RST; eta_q = ETA_LIMIT_RST; dcnt_q = DPHI_JET_COUNT_RST;
        clear_event();
    end

    always @(posedge aclk) begin
        summary_t e;
        if (!aresetn) begin
            thr_q  <= PT_THRESHOLD_RST;
            eta_q  <= ETA_LIMIT_RST;
            dcnt_q <= DPHI_JET_COUNT_RST;
            clear_event();
            summaries.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PT_THRESHOLD:   thr_q  <= cfg_data;
                    REG_ETA_LIMIT:      eta_q  <= cfg_data[8:0];
                    REG_DPHI_JET_COUNT: dcnt_q <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_jet_valid) add_jet(s_jet_momentum, s_jet_eta, s_jet_angle);
                if (s_last_jet) close_event(s_met_magnitude, s_met_angle);
            end
            if (m_valid && m_ready) begin
                if (summaries.size() == 0) begin
                    report_mismatch("unexpected summary", m_scalar_sum, -1);
                end else begin
                    e = summaries.pop_front();
                    if (m_good_jet_count != e.count)
                        report_mismatch("good_jet_count", m_good_jet_count, e.count);
                    if (m_scalar_sum != e.ht)
                        report_mismatch("scalar_sum", m_scalar_sum, e.ht);
                    if (m_vector_sum_magnitude != e.mht)
                        report_mismatch("vector_sum_magnitude", m_vector_sum_magnitude, e.mht);
                    if (m_met_mht_ratio != e.ratio)
                        report_mismatch("met_mht_ratio", m_met_mht_ratio, e.ratio);
                    if (m_lead_momentum != e.lead)
                        report_mismatch("lead_momentum", m_lead_momentum, e.lead);
                    if (m_second_momentum != e.second)
                        report_mismatch("second_momentum", m_second_momentum, e.second);
                    if (m_min_delta_angle != e.dphi)
                        report_mismatch("min_delta_angle", m_min_delta_angle, e.dphi);
                end
            end
        end
    end
endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import jhms_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready;
    logic s_jet_valid = 1'b0;
    logic [15:0] s_jet_momentum = '0;
    logic signed [9:0] s_jet_eta = '0;
    logic signed [ANGLE_BITS-1:0] s_jet_angle = '0;
    logic [15:0] s_met_magnitude = '0;
    logic signed [ANGLE_BITS-1:0] s_met_angle = '0;
    logic s_last_jet = 1'b0;
    logic m_valid, m_ready = 1'b0;
    logic [6:0] m_good_jet_count;
    logic [21:0] m_scalar_sum, m_vector_sum_magnitude;
    logic [15:0] m_met_mht_ratio, m_lead_momentum, m_second_momentum;
    logic signed [12:0] m_min_delta_angle;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int fail_count, pending;
    int send_idle = 0;    // percent of cycles the sender idles
    int recv_stall = 0;   // percent of cycles the receiver stalls
    bit hold_off = 0;     // long receiver hold-off in progress
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    jet_ht_mht_summary_top DUT (.*);

    jhms_summary_checker checker_i (.*);

    // Receiver: stall at random, or hold off entirely during the pressure phase
    always @(posedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end

    // Watchdog: count cycles in which no word moves on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** jet_ht_mht_summary_top: FAILED **");
            $finish;
        end
    end

    // Offer one word and hold it until accepted; valid drops only when idling
    task automatic send_word(bit jv, logic [15:0] pt, logic signed [9:0] eta,
                             logic signed [ANGLE_BITS-1:0] ang, logic [15:0] met,
                             logic signed [ANGLE_BITS-1:0] mang, bit last);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_jet_valid     <= jv;
        s_jet_momentum  <= pt;
        s_jet_eta       <= eta;
        s_jet_angle     <= ang;
        s_met_magnitude <= met;
        s_met_angle     <= mang;
        s_last_jet      <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, drain outstanding summaries, then let any work in flight finish
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(logic [15:0] thr, logic [15:0] eta, logic [15:0] dc);
        settle();
        write_reg(REG_PT_THRESHOLD, thr);
        write_reg(REG_ETA_LIMIT, eta);
        write_reg(REG_DPHI_JET_COUNT, dc);
        cfg_valid <= 1'b0;
    endtask

    // One random event: mostly realistic jets, sometimes noise
    task automatic random_event();
        int n;
        bit jv;
        logic [15:0] pt;
        n = ($urandom_range(19) == 0) ? $urandom_range(70) : $urandom_range(8);
        for (int i = 0; i < n; i++) begin
            jv = ($urandom_range(9) != 0);
            pt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
            send_word(jv, pt, 10'($urandom), 12'($urandom), 16'($urandom),
                      12'($urandom), 1'b0);
        end
        jv = $urandom_range(1);
        send_word(jv, 16'($urandom_range(3000)), 10'($urandom), 12'($urandom),
                  ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom),
                  12'($urandom), 1'b1);
    endtask

    task automatic random_phase(int events);
        repeat (events) random_event();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty event, lone empty word, extremes of momentum and angle
        send_word(0, 0, 0, 0, 0, 0, 1);
        send_word(0, 0, 0, 0, 100, 0, 0);
        send_word(1, 16'hFFFF, 10'sd0, 12'sh7FF, 16'hFFFF, -12'sd2048, 1);
        send_word(1, 500, -10'sd512, -12'sd2048, 0, 12'sd2047, 1);
        // Equal momenta keep arrival order, with seven jets ranked into four
        for (int i = 0; i < 6; i++)
            send_word(1, (i < 3) ? 16'd1000 : 16'd3000, 10'sd249, 12'(i * 600),
                      1000, 12'sd1024, 0);
        send_word(1, 16'd121, -10'sd249, 12'sd1, 1000, 12'sd1024, 1);
        // Cut edges: exactly at threshold and at eta limit are rejected
        send_word(1, 16'd120, 10'sd0, 12'sd0, 50, 12'sd0, 0);
        send_word(1, 16'd200, 10'sd250, 12'sd0, 50, 12'sd0, 0);
        send_word(1, 16'd200, -10'sd250, 12'sd0, 50, 12'sd0, 1);
        // Too many jets: only the first MAX_JETS count
        for (int i = 0; i < MAX_JETS + 4; i++)
            send_word(1, 16'hFFFF, 10'sd0, 12'($urandom), 0, 0, i == MAX_JETS + 3);

        // Register extremes: zero and large dphi counts, open and shut cuts
        apply_settings(16'd0, 16'd511, 16'd0);
        random_phase(20);
        apply_settings(16'hFFFF, 16'd0, 16'd7);
        random_phase(10);
        apply_settings(16'd30, 16'd300, 16'd1);
        random_phase(30);

        // Pressure: receiver holds off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
            random_phase(20);
        join

        apply_settings(16'd100, 16'd250, 16'd4);
        random_phase(40);
        send_idle = 71;
        random_phase(40);
        send_idle = 0; recv_stall = 71;
        apply_settings(16'd0, 16'd511, 16'd2);
        random_phase(40);
        send_idle = 31; recv_stall = 31;
        apply_settings(16'd300, 16'd150, 16'd3);
        random_phase(40);
        send_idle = 0; recv_stall = 0;

        settle();
        if (fail_count == 0)
            $display("** jet_ht_mht_summary_top: PASSED **");
        else
            $display("** jet_ht_mht_summary_top: FAILED **");
        $finish;
    end
endmodule

@@ sim.f @@
src/jhms_pkg.sv
src/jhms_lead_cell.sv
src/jhms_sqrt.sv
src/jhms_div.sv
src/jet_ht_mht_summary_top.sv
tb/jhms_summary_checker.sv
tb/testbench.sv
